[rtl/assert_macros.svh]
// Assertion helpers, removed in synthesis builds
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

[rtl/atce_pkg.sv]
package atce_pkg;

  localparam logic [23:0] DefaultGray = 24'hC9D1D9;
  localparam int unsigned TabSpaces = 4;

  typedef enum logic [1:0] {
    OP_STREAM = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } opcode_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
    logic [9:0] read_row;
    logic [7:0] read_col;
    logic       end_of_message;
  } req_t;

  typedef struct packed {
    logic [7:0]  cell_char;
    logic [23:0] cell_color;
    logic [8:0]  cursor_row_out;
    logic [6:0]  cursor_col_out;
    logic [23:0] pen_color_out;
  } rsp_t;

  // work handed from the front end to the back end
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_PRINT,
    CMD_TAB,
    CMD_NEWLINE,
    CMD_CR,
    CMD_BS,
    CMD_READ,
    CMD_CLEAR
  } cmd_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [7:0]  ch;
    logic [9:0]  row;
    logic [7:0]  col;
    logic [23:0] pen;
  } cmd_t;

  typedef enum logic [1:0] {
    ESC_IDLE = 2'd0,
    ESC_SEEN = 2'd1,
    ESC_CSI  = 2'd2
  } esc_e;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_DISPATCH,
    BK_WRITE,
    BK_SCROLL,
    BK_RD_ADDR,
    BK_RD_WAIT,
    BK_RD_DATA,
    BK_WIPE,
    BK_RESPOND
  } bk_state_e;

  function automatic logic [23:0] sgr_color(input logic [6:0] code, input logic [23:0] pen);
    logic [23:0] c;
    c = pen;
    case (code)
      7'd0:          c = 24'hC9D1D9;
      7'd31, 7'd91:  c = 24'hF85149;
      7'd32, 7'd92:  c = 24'h3FB950;
      7'd33, 7'd93:  c = 24'hE3B341;
      7'd34, 7'd94:  c = 24'h58A6FF;
      7'd35, 7'd95:  c = 24'hBC8CFF;
      7'd36, 7'd96:  c = 24'h39D2C0;
      7'd37, 7'd97:  c = 24'hF0F6FC;
      7'd90:         c = 24'h6E7681;
      default:       c = pen;
    endcase
    return c;
  endfunction

endpackage

[rtl/ansi_text_console_engine.sv]
// ANSI text console: a character grid with per-cell colour, cursor and pen.
// Request channel (req_valid_i / req_stall_o / req_i): one request per item,
//   taken when valid is high and stall low. Opcodes: stream byte, read cell,
//   clear screen, no-op. ESC [ n m picks the pen colour.
// Response channel (rsp_valid_o / rsp_stall_i / rsp_o): exactly one response
//   per request, in order; it holds while rsp_stall_i is high.
// The front end parses escapes in the accept cycle and pushes a command into
//   a two-entry queue; the back end sequences the cell memories, one memory
//   access per cycle through a single write port and a registered read port.
// A newline on the last row clears the new bottom row.
// Clear screen sweeps every cell.
// The back end takes the next request the cycle after a response is taken,
//   so it handles one request at a time.
// After reset the back end sweeps every cell to initialise the grid;
// requests queue up (two) and then stall until the sweep ends.
// A stalled response blocks the back end; the queue then fills and req_stall_o
//   rises.
module ansi_text_console_engine #(
  parameter int unsigned ROWS = 512,
  parameter int unsigned COLS = 80
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_stall_o,
  input  atce_pkg::req_t  req_i,
  output logic            rsp_valid_o,
  input  logic            rsp_stall_i,
  output atce_pkg::rsp_t  rsp_o
);
  import atce_pkg::*;

  logic cmd_valid, q_full, q_empty, q_pop;
  cmd_t cmd, head;

  atce_front u_front (
    .clk_i, .rst_ni, .in_valid_i(req_valid_i), .in_stall_o(req_stall_o), .in_data_i(req_i),
    .cmd_valid_o(cmd_valid), .cmd_full_i(q_full), .cmd_o(cmd));

  atce_queue u_queue (
    .clk_i, .rst_ni, .push_i(cmd_valid), .push_data_i(cmd), .full_o(q_full),
    .pop_i(q_pop), .empty_o(q_empty), .head_o(head));

  atce_back #(.Rows(ROWS), .Cols(COLS)) u_back (
    .clk_i, .rst_ni, .q_empty_i(q_empty), .q_head_i(head), .q_pop_o(q_pop),
    .out_valid_o(rsp_valid_o), .out_stall_i(rsp_stall_i), .out_data_o(rsp_o));

endmodule

[rtl/atce_ram.sv]
module atce_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/atce_front.sv]
`include "assert_macros.svh"
// Escape parser and pen colour; turns requests into back-end commands.
module atce_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  atce_pkg::req_t  in_data_i,
  output logic            cmd_valid_o,
  input  logic            cmd_full_i,
  output atce_pkg::cmd_t  cmd_o
);
  import atce_pkg::*;

  esc_e        esc_q, esc_d;
  logic [6:0]  code_q, code_d;
  logic [23:0] pen_q, pen_d;
  logic        take;
  logic [10:0] code_x10;
  logic [7:0]  b;
  cmd_t        c;

  assign in_stall_o  = cmd_full_i;
  assign take        = in_valid_i && !cmd_full_i;
  assign cmd_valid_o = take;
  assign b           = in_data_i.data_byte;
  assign code_x10    = {4'd0, code_q} * 11'd10 + {7'd0, b[3:0]};

  function automatic cmd_e plain_cmd(input logic [7:0] x);
    cmd_e r;
    if (x == 8'd10)      r = CMD_NEWLINE;
    else if (x == 8'd13) r = CMD_CR;
    else if (x == 8'd8)  r = CMD_BS;
    else if (x == 8'd9)  r = CMD_TAB;
    else if (x >= 8'd32) r = CMD_PRINT;
    else                 r = CMD_NONE;
    return r;
  endfunction

  always_comb begin
    esc_d = esc_q;
    code_d = code_q;
    pen_d = pen_q;
    c.cmd = CMD_NONE;
    c.ch  = b;
    c.row = in_data_i.read_row;
    c.col = in_data_i.read_col;
    unique case (opcode_e'(in_data_i.opcode))
      OP_READ:  c.cmd = CMD_READ;
      OP_CLEAR: c.cmd = CMD_CLEAR;
      OP_NOP:   c.cmd = CMD_NONE;
      OP_STREAM: begin
        unique case (esc_q)
          ESC_SEEN: begin
            if (b == 8'd91) begin
              esc_d = ESC_CSI;
              code_d = '0;
            end else if (b == 8'd27) begin
              esc_d = ESC_SEEN;
            end else begin
              esc_d = ESC_IDLE;
              c.cmd = plain_cmd(b);
            end
          end
          ESC_CSI: begin
            if (b >= 8'd48 && b <= 8'd57) begin
              code_d = (code_x10 > 11'd127) ? 7'd127 : code_x10[6:0];
            end else begin
              esc_d = ESC_IDLE;
              code_d = '0;
              if (b == 8'd109) pen_d = sgr_color(code_q, pen_q);
              else             c.cmd = plain_cmd(b);
            end
          end
          default: begin
            if (b == 8'd27) esc_d = ESC_SEEN;
            else            c.cmd = plain_cmd(b);
          end
        endcase
      end
      default: c.cmd = CMD_NONE;
    endcase
    if (in_data_i.end_of_message) begin
      esc_d = ESC_IDLE;
      code_d = '0;
    end
    c.pen = pen_d;
  end

  assign cmd_o = c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q  <= ESC_IDLE;
      code_q <= '0;
      pen_q  <= DefaultGray;
    end else if (take) begin
      esc_q  <= esc_d;
      code_q <= code_d;
      pen_q  <= pen_d;
    end
  end

  `ASSERT_NEVER(a_code_idle, clk_i, rst_ni, esc_q == ESC_IDLE && code_q != 7'd0,
                "sgr code held while idle")
  `ASSERT_NEVER(a_no_take_full, clk_i, rst_ni, cmd_valid_o && cmd_full_i,
                "command pushed into full queue")
  `ASSERT_IMPL(a_pen_hold, clk_i, rst_ni, !take |=> $stable(pen_q), "pen changed idle")

endmodule

[rtl/atce_queue.sv]
`include "assert_macros.svh"
// Two-entry command queue between front and back end.
module atce_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  atce_pkg::cmd_t  push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output atce_pkg::cmd_t  head_o
);
  import atce_pkg::*;

  cmd_t       buf_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign head_o  = buf_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) buf_q[wp_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  `ASSERT_NEVER(a_cnt, clk_i, rst_ni, cnt_q == 2'd3, "queue count overflow")
  `ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, pop_i && empty_o, "pop from empty queue")
  `ASSERT_NEVER(a_ptr, clk_i, rst_ni, (cnt_q != 2'd1) && (wp_q != rp_q),
                "queue pointers disagree with count")

endmodule

[rtl/atce_back.sv]
`include "assert_macros.svh"
// Grid sequencer: cursor, ring pointer, cell memories, clearing passes.
module atce_back #(
  parameter int unsigned Rows = 512,
  parameter int unsigned Cols = 80
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  atce_pkg::cmd_t  q_head_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output atce_pkg::rsp_t  out_data_o
);
  import atce_pkg::*;

  localparam int unsigned Cells = Rows * Cols;
  localparam int unsigned AW = $clog2(Cells);
  localparam int unsigned RW = $clog2(Rows);
  localparam int unsigned CW = $clog2(Cols + 1);

  bk_state_e   st_q, st_d;
  cmd_t        cmd_q, cmd_d;
  logic [RW-1:0] top_q, top_d, crow_q, crow_d;
  logic [CW-1:0] ccol_q, ccol_d;
  logic [2:0]  tab_q, tab_d;
  logic [AW-1:0] wipe_q, wipe_d;
  logic        boot_q, boot_d;
  logic [RW-1:0] phys_q, phys_d;
  logic [AW-1:0] base_q, base_d;
  logic [CW-1:0] sc_q, sc_d;
  logic        inrange_q, inrange_d;
  rsp_t        rsp_q, rsp_d;
  logic        ov_q, ov_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wch, rch;
  logic [23:0]   wcol, rcol;
  logic          wcol_en;
  logic [RW:0]   psum;
  logic [RW-1:0] phys_c;

  atce_ram #(.Width(8), .Depth(Cells)) u_chr (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wch), .raddr_i(raddr), .rdata_o(rch));
  atce_ram #(.Width(24), .Depth(Cells)) u_clr (
    .clk_i, .we_i(we && wcol_en), .waddr_i(waddr), .wdata_i(wcol), .raddr_i(raddr),
    .rdata_o(rcol));

  // physical row of the cursor row, used for writes
  assign psum   = {1'b0, top_q} + {1'b0, crow_q};
  assign phys_c = (psum >= (RW+1)'(Rows)) ? RW'(psum - (RW+1)'(Rows)) : psum[RW-1:0];

  assign out_valid_o = ov_q;
  assign out_data_o  = rsp_q;

  always_comb begin
    logic [RW:0]   rsum;
    st_d = st_q; cmd_d = cmd_q; top_d = top_q; crow_d = crow_q; ccol_d = ccol_q;
    tab_d = tab_q; wipe_d = wipe_q; boot_d = boot_q; phys_d = phys_q; base_d = base_q;
    sc_d = sc_q; inrange_d = inrange_q; rsp_d = rsp_q; ov_d = ov_q;
    we = 1'b0; waddr = base_q + AW'(ccol_q); wch = cmd_q.ch; wcol = cmd_q.pen;
    wcol_en = 1'b1; raddr = base_q + AW'(sc_q); q_pop_o = 1'b0;
    rsum = '0;
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    unique case (st_q)
      BK_IDLE: begin
        if (!q_empty_i && !ov_q) begin
          q_pop_o = 1'b1;
          cmd_d = q_head_i;
          tab_d = 3'(TabSpaces);
          st_d = BK_DISPATCH;
        end
      end
      BK_DISPATCH: begin
        // physical row base of the cursor
        phys_d = phys_c;
        base_d = AW'(phys_c) * AW'(Cols);
        unique case (cmd_q.cmd)
          CMD_PRINT, CMD_TAB: begin
            if (ccol_q == CW'(Cols)) begin
              st_d = BK_SCROLL;
            end else begin
              st_d = BK_WRITE;
            end
          end
          CMD_NEWLINE: st_d = BK_SCROLL;
          CMD_CR: begin
            ccol_d = '0;
            st_d = BK_RESPOND;
          end
          CMD_BS: begin
            if (ccol_q != '0) begin
              ccol_d = ccol_q - 1'b1;
              st_d = BK_WRITE;
            end else begin
              st_d = BK_RESPOND;
            end
          end
          CMD_READ: st_d = BK_RD_ADDR;
          CMD_CLEAR: begin
            wipe_d = '0;
            st_d = BK_WIPE;
          end
          default: st_d = BK_RESPOND;
        endcase
      end
      BK_SCROLL: begin
        // line advance for a newline or a wrap, possibly with a row clear at the bottom
        ccol_d = '0;
        if (crow_q != RW'(Rows - 1)) begin
          crow_d = crow_q + 1'b1;
          st_d = (cmd_q.cmd == CMD_NEWLINE) ? BK_RESPOND : BK_DISPATCH;
        end else begin
          sc_d = '0;
          base_d = AW'(top_q) * AW'(Cols);
          st_d = BK_WIPE;
          boot_d = 1'b0;
        end
      end
      BK_WRITE: begin
        we = 1'b1;
        if (cmd_q.cmd == CMD_BS) begin
          wch = '0;
          wcol_en = 1'b0;
          st_d = BK_RESPOND;
        end else begin
          if (cmd_q.cmd == CMD_TAB) wch = 8'd32;
          ccol_d = ccol_q + 1'b1;
          if (cmd_q.cmd == CMD_TAB && tab_q != 3'd1) begin
            tab_d = tab_q - 1'b1;
            st_d = BK_DISPATCH;
          end else begin
            st_d = BK_RESPOND;
          end
        end
      end
      BK_RD_ADDR: begin
        inrange_d = ({1'b0, cmd_q.row} < 11'(Rows)) && ({1'b0, cmd_q.col} < 9'(Cols));
        rsum = {1'b0, top_q} + (RW+1)'(cmd_q.row);
        phys_d = (rsum >= (RW+1)'(Rows)) ? RW'(rsum - (RW+1)'(Rows)) : rsum[RW-1:0];
        st_d = BK_RD_WAIT;
      end
      BK_RD_WAIT: begin
        base_d = AW'(phys_q) * AW'(Cols);
        sc_d = CW'(cmd_q.col);
        st_d = BK_RD_DATA;
      end
      BK_RD_DATA: begin
        // raddr presented this cycle; data comes next cycle
        st_d = BK_RESPOND;
        inrange_d = inrange_q;
        sc_d = '0;
        cmd_d.cmd = CMD_READ;
      end
      BK_WIPE: begin
        we = 1'b1;
        wch = '0;
        wcol = DefaultGray;
        if (cmd_q.cmd == CMD_CLEAR || boot_q) begin
          waddr = wipe_q;
          if (wipe_q == AW'(Cells - 1)) begin
            boot_d = 1'b0;
            top_d = '0; crow_d = '0; ccol_d = '0;
            st_d = boot_q ? BK_IDLE : BK_RESPOND;
          end else begin
            wipe_d = wipe_q + 1'b1;
          end
        end else begin
          waddr = base_q + AW'(sc_q);
          if (sc_q == CW'(Cols - 1)) begin
            top_d = (top_q == RW'(Rows - 1)) ? '0 : top_q + 1'b1;
            st_d = (cmd_q.cmd == CMD_NEWLINE) ? BK_RESPOND : BK_DISPATCH;
          end else begin
            sc_d = sc_q + 1'b1;
          end
        end
      end
      BK_RESPOND: begin
        rsp_d.cell_char  = '0;
        rsp_d.cell_color = '0;
        if (cmd_q.cmd == CMD_READ && inrange_q) begin
          rsp_d.cell_char  = rch;
          rsp_d.cell_color = rcol;
        end
        rsp_d.cursor_row_out = 9'(crow_q);
        rsp_d.cursor_col_out = 7'(ccol_q);
        rsp_d.pen_color_out  = cmd_q.pen;
        ov_d = 1'b1;
        st_d = BK_IDLE;
      end
      default: st_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; phys_q <= phys_d; base_q <= base_d; sc_q <= sc_d;
    inrange_q <= inrange_d; rsp_q <= rsp_d; tab_q <= tab_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BK_WIPE; top_q <= '0; crow_q <= '0; ccol_q <= '0;
      wipe_q <= '0; boot_q <= 1'b1; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; top_q <= top_d; crow_q <= crow_d; ccol_q <= ccol_d;
      wipe_q <= wipe_d; boot_q <= boot_d; ov_q <= ov_d;
    end
  end

  `ASSERT_NEVER(a_col_range, clk_i, rst_ni, ccol_q > CW'(Cols), "cursor column past width")
  `ASSERT_NEVER(a_pop_busy, clk_i, rst_ni, q_pop_o && st_q != BK_IDLE, "pop while busy")
  `ASSERT_IMPL(a_out_hold, clk_i, rst_ni, ov_q && out_stall_i |=> ov_q && $stable(rsp_q),
               "stalled result changed")

endmodule
